/* src/linear_key_value_table_core_assert.svh */
// ----------------------------------------------------------------------------
// linear_key_value_table_core assertion macros
// Shared concurrent assertion forms for the key/value table checkers.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define LKV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("key/value table assertion failed");

// next-cycle implication
`define LKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("key/value table assertion failed");

`endif

/* src/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, operation codes and cell control type of the key/value table.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int POS_W          = 8;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT     = 3'd0,
        K_UPDATE     = 3'd1,
        K_INS_UPD    = 3'd2,
        K_ERASE      = 3'd3,
        K_CONTAINS   = 3'd4,
        K_GET_KEY    = 3'd5,
        K_GET_POS    = 3'd6,
        K_UNUSED     = 3'd7
    } t_kind;

    typedef struct packed {
        logic match_en;
        logic append;
        logic update;
        logic erase;
    } t_cell_ctl;

endpackage

/* src/lkv_cell.sv */
// ----------------------------------------------------------------------------
// lkv_cell
// One table slot: holds a key/value pair, compares against the request and
// takes a write, an update or its upper neighbor's entry on erase.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int CNT_W      = 9,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [POS_W-1:0]      i_pos,
    input  logic [CNT_W-1:0]      i_slot,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [VALUE_BITS-1:0] i_next_value,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_hit,
    output logic                  o_psel
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_CMP = CMP_W'(INDEX);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_hit;
    logic                  r_psel;
    logic                  live;

    assign live = IDX < i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.match_en) begin
            r_hit  <= live && (r_key == i_key);
            r_psel <= live && (IDX_CMP == CMP_W'(i_pos));
        end
        if (i_ctl.append && (IDX == i_count)) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.update && r_hit) begin
            r_value <= i_value;
        end else if (i_ctl.erase && (IDX >= i_slot)) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_hit   = r_hit;
    assign o_psel  = r_psel;

endmodule

/* src/linear_key_value_table_core.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table_core
// Bounded key/value table kept as a packed list in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_kind, i_lookup_key, i_new_value, i_position and
//   raise start; the beat is taken at a clock edge where start is high and
//   busy is low. busy stays high for the one execute cycle that follows.
//   Result channel: o_valid marks each result beat for exactly one cycle;
//   the receiver cannot stall it and must take it in that cycle.
// Timing:
//   Accept edge: every cell compares its entry against the key and position.
//   Execute edge: hits are reduced, the write, update or shift is applied to
//   the cells and the result is registered. The result shows in the cycle
//   after the execute cycle, and a new request can be taken in that same
//   cycle and not before, as each request runs the compare and execute
//   steps of the cell row.
// Reset: synchronous, active low; clears the entry count so the table is
//   empty. Entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module linear_key_value_table_core
    import lkv_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic [POS_W-1:0]      i_position,
    output logic                  o_valid,
    output logic                  o_success,
    output logic [KEY_BITS-1:0]   o_found_key,
    output logic [VALUE_BITS-1:0] o_found_value,
    output logic [CNT_W-1:0]      o_entry_count,
    output logic                  o_is_empty
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    t_kind                 r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid, n_valid;
    logic                  r_success, n_success;
    logic [KEY_BITS-1:0]   r_found_key, n_found_key;
    logic [VALUE_BITS-1:0] r_found_value, n_found_value;

    logic                  accept;
    t_cell_ctl             ctl;
    logic [KEY_BITS-1:0]   cmp_key;
    logic [CNT_W-1:0]      slot;
    logic                  hit;
    logic                  psel_any;
    logic [VALUE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]   pos_key;
    logic [VALUE_BITS-1:0] pos_value;
    logic                  full;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_hit;
    logic [CAPACITY-1:0]   cell_psel;

    assign accept  = start && (r_state == S_IDLE);
    assign busy    = (r_state == S_EXEC);
    assign cmp_key = busy ? r_key : i_lookup_key;
    assign full    = (r_count == FULL_COUNT);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0]   next_key;
        logic [VALUE_BITS-1:0] next_value;
        if (g == CAPACITY - 1) begin : g_last
            assign next_key   = '0;
            assign next_value = '0;
        end else begin : g_mid
            assign next_key   = cell_key[g+1];
            assign next_value = cell_value[g+1];
        end
        lkv_cell #(
            .INDEX      (g),
            .CNT_W      (CNT_W),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_key        (cmp_key),
            .i_value      (r_value),
            .i_count      (r_count),
            .i_pos        (i_position),
            .i_slot       (slot),
            .i_next_key   (next_key),
            .i_next_value (next_value),
            .o_key        (cell_key[g]),
            .o_value      (cell_value[g]),
            .o_hit        (cell_hit[g]),
            .o_psel       (cell_psel[g])
        );
    end

    // at most one live cell hits and at most one is selected by position
    always_comb begin
        slot      = '0;
        hit_value = '0;
        pos_key   = '0;
        pos_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_hit[i]) begin
                slot      = slot | CNT_W'(i);
                hit_value = hit_value | cell_value[i];
            end
            if (cell_psel[i]) begin
                pos_key   = pos_key | cell_key[i];
                pos_value = pos_value | cell_value[i];
            end
        end
        hit      = |cell_hit;
        psel_any = |cell_psel;
    end

    always_comb begin
        ctl           = '0;
        ctl.match_en  = accept;
        n_state       = r_state;
        n_count       = r_count;
        n_valid       = 1'b0;
        n_success     = 1'b0;
        n_found_key   = r_key;
        n_found_value = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                case (r_kind)
                    K_INSERT: begin
                        ctl.append = !hit && !full;
                    end
                    K_UPDATE: begin
                        ctl.update = hit;
                    end
                    K_INS_UPD: begin
                        ctl.update = hit;
                        ctl.append = !hit && !full;
                    end
                    K_ERASE: begin
                        ctl.erase = hit;
                    end
                    K_CONTAINS: begin
                        n_success = hit;
                    end
                    K_GET_KEY: begin
                        n_success = hit;
                        if (hit) begin
                            n_found_value = hit_value;
                        end
                    end
                    K_GET_POS: begin
                        n_success = psel_any;
                        if (psel_any) begin
                            n_found_key   = pos_key;
                            n_found_value = pos_value;
                        end
                    end
                    default: begin
                        n_success = 1'b0;
                    end
                endcase
                if (ctl.append) begin
                    n_count   = r_count + 1'b1;
                    n_success = 1'b1;
                end
                if (ctl.update) begin
                    n_success = 1'b1;
                end
                if (ctl.erase) begin
                    n_count   = r_count - 1'b1;
                    n_success = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        if (accept) begin
            r_kind  <= t_kind'(i_kind);
            r_key   <= i_lookup_key;
            r_value <= i_new_value;
        end
        if (busy) begin
            r_success     <= n_success;
            r_found_key   <= n_found_key;
            r_found_value <= n_found_value;
        end
    end

    assign o_valid       = r_valid;
    assign o_success     = r_success;
    assign o_found_key   = r_found_key;
    assign o_found_value = r_found_value;
    assign o_entry_count = r_count;
    assign o_is_empty    = (r_count == '0);

endmodule

/* src/lkv_checker.sv */
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the key/value table request and result timing and entry count.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_core_assert.svh"

module lkv_checker
    import lkv_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [CNT_W-1:0]      o_entry_count,
    input logic                  o_is_empty
);

    `LKV_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `LKV_ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, busy, o_valid && !busy)
    `LKV_ASSERT_NOW(a_result_after_exec, i_clk, i_rst_n, o_valid, $past(busy))
    `LKV_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid, (o_entry_count <= CNT_W'(CAPACITY)) && (o_is_empty == (o_entry_count == '0)))
    `LKV_ASSERT_NEXT(a_count_steady, i_clk, i_rst_n, !busy, $stable(o_entry_count))

endmodule

bind linear_key_value_table_core lkv_checker #(
    .CAPACITY   (CAPACITY),
    .CNT_W      (CNT_W)
) u_lkv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);

/* sim/linear_key_value_table_core_tb.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table_core_tb
// Self-checking bench for the packed-list key/value table. Requests are sent
// through the start/busy handshake with random gaps. A monitor keeps a shadow
// table, predicts one result per accepted beat and compares every strobed
// result field by field. Covers the empty table, a filled table, the full-table
// rejections, erase shifting and random mixes of all operations.
// ----------------------------------------------------------------------------
module linear_key_value_table_core_tb;
    import lkv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD = 10;
    localparam int  CAPACITY   = CAPACITY_DEF;
    localparam int  CNT_W      = $clog2(CAPACITY + 1);
    localparam time RUN_LIMIT  = 2_000_000;

    typedef struct {
        logic             success;
        logic [31:0]      key;
        logic [31:0]      value;
        logic [CNT_W-1:0] count;
        logic             empty;
    } table_result_t;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic [KIND_W-1:0] i_kind       = '0;
    logic [31:0]       i_lookup_key = '0;
    logic [31:0]       i_new_value  = '0;
    logic [POS_W-1:0]  i_position   = '0;
    logic              busy;
    logic              o_valid;
    logic              o_success;
    logic [31:0]       o_found_key;
    logic [31:0]       o_found_value;
    logic [CNT_W-1:0]  o_entry_count;
    logic              o_is_empty;

    logic [31:0]   shadow_keys [CAPACITY];
    logic [31:0]   shadow_vals [CAPACITY];
    int            shadow_count = 0;
    table_result_t expected_results[$];

    logic [31:0] snapshot_keys[$];
    int          snapshot_count = 0;
    logic [31:0] key_pool [16];

    int idle_pct       = 20;
    int errors         = 0;
    int beats_taken    = 0;
    int results_seen   = 0;
    int peak_count     = 0;

    linear_key_value_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_lookup_key  (i_lookup_key),
        .i_new_value   (i_new_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_success     (o_success),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit append_entry(input logic [31:0] key, input logic [31:0] val);
        if (shadow_count >= CAPACITY) return 1'b0;
        shadow_keys[shadow_count] = key;
        shadow_vals[shadow_count] = val;
        shadow_count++;
        return 1'b1;
    endfunction

    function automatic table_result_t apply_table_op(input t_kind kind,
                                                     input logic [31:0] key,
                                                     input logic [31:0] val,
                                                     input logic [POS_W-1:0] pos);
        table_result_t r;
        int slot;
        bit hit;
        slot = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_keys[i] == key) slot = i;
        end
        hit = slot < shadow_count;
        r.success = 1'b0;
        r.key     = key;
        r.value   = '0;
        case (kind)
            K_INSERT: begin
                if (!hit) r.success = append_entry(key, val);
            end
            K_UPDATE: begin
                if (hit) begin
                    shadow_vals[slot] = val;
                    r.success = 1'b1;
                end
            end
            K_INS_UPD: begin
                if (hit) begin
                    shadow_vals[slot] = val;
                    r.success = 1'b1;
                end else begin
                    r.success = append_entry(key, val);
                end
            end
            K_ERASE: begin
                if (hit) begin
                    for (int j = slot; j < shadow_count - 1; j++) begin
                        shadow_keys[j] = shadow_keys[j + 1];
                        shadow_vals[j] = shadow_vals[j + 1];
                    end
                    shadow_count--;
                    r.success = 1'b1;
                end
            end
            K_CONTAINS: r.success = hit;
            K_GET_KEY: begin
                if (hit) begin
                    r.value   = shadow_vals[slot];
                    r.success = 1'b1;
                end
            end
            K_GET_POS: begin
                if (int'(pos) < shadow_count) begin
                    r.key     = shadow_keys[pos];
                    r.value   = shadow_vals[pos];
                    r.success = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = shadow_count[CNT_W-1:0];
        r.empty = shadow_count == 0;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_monitor
        table_result_t want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(apply_table_op(t_kind'(i_kind), i_lookup_key,
                                                          i_new_value, i_position));
                beats_taken++;
                if (shadow_count > peak_count) peak_count = shadow_count;
            end
            if (o_valid) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (o_success !== want.success)
                        report_mismatch($sformatf("success got %b want %b",
                                                  o_success, want.success));
                    if (o_found_key !== want.key)
                        report_mismatch($sformatf("found_key got %h want %h",
                                                  o_found_key, want.key));
                    if (o_found_value !== want.value)
                        report_mismatch($sformatf("found_value got %h want %h",
                                                  o_found_value, want.value));
                    if (o_entry_count !== want.count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                                  o_entry_count, want.count));
                    if (o_is_empty !== want.empty)
                        report_mismatch($sformatf("is_empty got %b want %b",
                                                  o_is_empty, want.empty));
                end
            end
        end
    end

    // hold start high across back-to-back beats; drop it only for a gap
    task automatic send_request(input t_kind kind, input logic [31:0] key,
                                input logic [31:0] val, input logic [POS_W-1:0] pos);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_lookup_key <= key;
        i_new_value  <= val;
        i_position   <= pos;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_table_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        snapshot_keys.delete();
        for (int i = 0; i < shadow_count; i++) snapshot_keys.push_back(shadow_keys[i]);
        snapshot_count = shadow_count;
    endtask

    task automatic test_empty_and_small_table();
        send_request(K_GET_POS,  32'h0000_0005, 32'h0,         8'd0);
        send_request(K_ERASE,    32'h0000_0005, 32'h0,         8'd0);
        send_request(K_UPDATE,   32'h0000_0005, 32'h1234_5678, 8'd0);
        send_request(K_CONTAINS, 32'h0000_0005, 32'h0,         8'd0);
        send_request(K_GET_KEY,  32'h0000_0005, 32'h0,         8'd0);
        send_request(K_UNUSED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(K_INSERT,   32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
        send_request(K_INSERT,   32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
        send_request(K_INSERT,   32'h0000_0000, 32'h0000_0001, 8'd0);
        send_request(K_UPDATE,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd0);
        send_request(K_INS_UPD,  32'h0000_0000, 32'h5A5A_5A5A, 8'd0);
        send_request(K_INS_UPD,  32'h8000_0000, 32'h0000_0001, 8'd0);
        send_request(K_GET_KEY,  32'h0000_0000, 32'h0,         8'd0);
        send_request(K_GET_POS,  32'h0000_0000, 32'h0,         8'd2);
        send_request(K_GET_POS,  32'h0000_0000, 32'h0,         8'd3);
        send_request(K_GET_POS,  32'h1357_9BDF, 32'h0,         8'd255);
        send_request(K_CONTAINS, 32'hFFFF_FFFF, 32'h0,         8'd0);
        send_request(K_ERASE,    32'hFFFF_FFFF, 32'h0,         8'd0);
        send_request(K_GET_POS,  32'h0000_0000, 32'h0,         8'd1);
        send_request(K_ERASE,    32'h0000_0000, 32'h0,         8'd0);
        send_request(K_ERASE,    32'h8000_0000, 32'h0,         8'd0);
        send_request(K_GET_KEY,  32'h8000_0000, 32'h0,         8'd0);
        send_request(K_CONTAINS, 32'h0000_0000, 32'h0,         8'd0);
        wait_table_idle();
    endtask

    task automatic test_full_table();
        logic [31:0] fresh_key;
        logic [31:0] first_key;
        logic [31:0] mid_key;
        logic [31:0] last_key;
        bit          present;
        while (shadow_count < CAPACITY) begin
            repeat (CAPACITY - shadow_count)
                send_request($urandom_range(1) ? K_INSERT : K_INS_UPD,
                             $urandom, $urandom, POS_W'($urandom_range(255)));
            wait_table_idle();
        end
        first_key = shadow_keys[0];
        mid_key   = shadow_keys[CAPACITY / 2];
        last_key  = shadow_keys[CAPACITY - 1];
        do begin
            fresh_key = $urandom;
            present   = 1'b0;
            for (int i = 0; i < shadow_count; i++)
                if (shadow_keys[i] == fresh_key) present = 1'b1;
        end while (present);
        send_request(K_INSERT,   fresh_key, $urandom,     8'd0);
        send_request(K_INS_UPD,  fresh_key, $urandom,     8'd0);
        send_request(K_INSERT,   mid_key,   $urandom,     8'd0);
        send_request(K_INS_UPD,  last_key,  32'hFFFF_FFFF, 8'd0);
        send_request(K_UPDATE,   first_key, 32'h0000_0000, 8'd0);
        send_request(K_GET_POS,  fresh_key, 32'h0,        8'd255);
        send_request(K_GET_KEY,  last_key,  32'h0,        8'd0);
        send_request(K_GET_POS,  fresh_key, 32'h0,        8'd0);
        send_request(K_ERASE,    first_key, 32'h0,        8'd0);
        send_request(K_GET_POS,  fresh_key, 32'h0,        8'd255);
        send_request(K_GET_POS,  fresh_key, 32'h0,        8'd254);
        send_request(K_CONTAINS, first_key, 32'h0,        8'd0);
        send_request(K_INSERT,   fresh_key, 32'hC0DE_0001, 8'd0);
        send_request(K_GET_POS,  32'h0,     32'h0,        8'd255);
        wait_table_idle();
    endtask

    task automatic test_random_mix(input int n_items, input int pct);
        t_kind       kind;
        logic [31:0] key;
        int          sel;
        int          pos_hi;
        idle_pct = pct;
        pos_hi   = (snapshot_count + 1 > 255) ? 255 : snapshot_count + 1;
        repeat (n_items) begin
            sel = $urandom_range(99);
            if (sel < 25)      kind = K_ERASE;
            else if (sel < 40) kind = K_INSERT;
            else if (sel < 50) kind = K_UPDATE;
            else if (sel < 65) kind = K_INS_UPD;
            else if (sel < 75) kind = K_CONTAINS;
            else if (sel < 85) kind = K_GET_KEY;
            else if (sel < 97) kind = K_GET_POS;
            else               kind = K_UNUSED;
            sel = $urandom_range(9);
            if (sel < 6 && snapshot_keys.size() != 0)
                key = snapshot_keys[$urandom_range(snapshot_keys.size() - 1)];
            else if (sel < 9)
                key = key_pool[$urandom_range(15)];
            else
                key = $urandom;
            send_request(kind, key, $urandom,
                         POS_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(pos_hi)));
        end
        wait_table_idle();
    endtask

    initial begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++) key_pool[i] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_small_table();
        test_full_table();
        test_random_mix(100, 20);
        test_random_mix(100, 0);
        test_random_mix(60, 20);

        $display("covered %0d request beats, %0d results checked, peak occupancy %0d of %0d",
                 beats_taken, results_seen, peak_count, CAPACITY);
        $display("all seven operations plus the unused code, empty and full table, %0d errors",
                 errors);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
